// ===== hdl/gbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gbd_pkg: shared types, codes and decode tables of the instruction decoder.
// Holds the operand and operation codes, the result record layout and the
// main opcode table, written as functions.
// ----------------------------------------------------------------------------
package gbd_pkg;

   // Prefix bytes and opcodes that need special handling.
   localparam logic [7:0] PREFIX_CB   = 8'hCB;
   localparam logic [7:0] PREFIX_DD   = 8'hDD;
   localparam logic [7:0] PREFIX_ED   = 8'hED;
   localparam logic [7:0] PREFIX_FD   = 8'hFD;
   localparam logic [7:0] OPC_LD_A_BC   = 8'h0A;
   localparam logic [7:0] OPC_LD_A_DE   = 8'h1A;
   localparam logic [7:0] OPC_LD_A_HLI  = 8'h2A;
   localparam logic [7:0] OPC_LD_A_HLD  = 8'h3A;
   localparam logic [7:0] OPC_LD_BC_A   = 8'h02;
   localparam logic [7:0] OPC_LD_DE_A   = 8'h12;
   localparam logic [7:0] OPC_LD_HLI_A  = 8'h22;
   localparam logic [7:0] OPC_LD_HLD_A  = 8'h32;
   localparam logic [7:0] OPC_LD_A16_SP = 8'h08;
   localparam logic [7:0] OPC_HALT      = 8'h76;
   localparam logic [7:0] OPC_LDH_N_A   = 8'hE0;
   localparam logic [7:0] OPC_LDH_A_N   = 8'hF0;
   localparam logic [7:0] OPC_LDH_C_A   = 8'hE2;
   localparam logic [7:0] OPC_LDH_A_C   = 8'hF2;
   localparam logic [7:0] OPC_LD_A16_A  = 8'hEA;
   localparam logic [7:0] OPC_LD_A_A16  = 8'hFA;
   localparam logic [7:0] OPC_LD_HL_SPN = 8'hF8;
   localparam logic [7:0] OPC_LD_SP_HL  = 8'hF9;
   localparam logic [7:0] HIGH_PAGE     = 8'hFF;

   // Number of immediate bytes that follow an opcode.
   typedef enum logic [1:0] {
      IMM_NONE = 2'd0,
      IMM_BYTE = 2'd1,
      IMM_WORD = 2'd2
   } imm_count_type;

   typedef enum logic [3:0] {
      OP_NOP    = 4'd0,
      OP_LOAD8  = 4'd1,
      OP_LOAD16 = 4'd2,
      OP_PUSH   = 4'd3,
      OP_POP    = 4'd4,
      OP_ADD    = 4'd5,
      OP_ADC    = 4'd6,
      OP_SUB    = 4'd7,
      OP_SBC    = 4'd8,
      OP_AND    = 4'd9,
      OP_OR     = 4'd10,
      OP_XOR    = 4'd11,
      OP_CP     = 4'd12,
      OP_INC    = 4'd13
   } op_kind_type;

   typedef enum logic [4:0] {
      OPD_NONE  = 5'd0,
      OPD_A     = 5'd1,
      OPD_B     = 5'd2,
      OPD_C     = 5'd3,
      OPD_D     = 5'd4,
      OPD_E     = 5'd5,
      OPD_H     = 5'd6,
      OPD_L     = 5'd7,
      OPD_BC    = 5'd8,
      OPD_DE    = 5'd9,
      OPD_HL    = 5'd10,
      OPD_SP    = 5'd11,
      OPD_AF    = 5'd12,
      OPD_IBC   = 5'd13,
      OPD_IDE   = 5'd14,
      OPD_IHL   = 5'd15,
      OPD_IHLD  = 5'd16,
      OPD_IHLI  = 5'd17,
      OPD_IMM8  = 5'd18,
      OPD_IMM16 = 5'd19,
      OPD_ADDR  = 5'd20,
      OPD_HIC   = 5'd21,
      OPD_SPIMM = 5'd22
   } operand_type;

   typedef enum logic [1:0] {
      FLAGS_DEFAULT = 2'd0,
      FLAGS_KEEP    = 2'd1,
      FLAGS_SP_ADD  = 2'd2
   } flag_rule_type;

   // Complete instruction handed from the byte gatherer to the decoder.
   typedef struct packed {
      logic [15:0] imm;
      logic [7:0]  opcode;
   } inst_type;

   // Result record; the first field sits in the highest bits.
   typedef struct packed {
      flag_rule_type flag_rule;
      logic [15:0]   immediate_value;
      operand_type   src_operand;
      operand_type   dest_operand;
      op_kind_type   op_kind;
   } rsp_type;

   // Immediate byte count of an opcode from the main table.
   function automatic imm_count_type imm_count(input logic [7:0] op);
      imm_count_type cnt;
      cnt = IMM_NONE;
      if (op < 8'h40 && op[2:0] == 3'd6) begin
         cnt = IMM_BYTE;
      end else if (op[7:6] == 2'b11 && op[2:0] == 3'd6) begin
         cnt = IMM_BYTE;
      end else if (op == OPC_LDH_N_A || op == OPC_LDH_A_N || op == OPC_LD_HL_SPN) begin
         cnt = IMM_BYTE;
      end else if (op == OPC_LD_A_A16 || op == OPC_LD_A16_A || op == OPC_LD_A16_SP) begin
         cnt = IMM_WORD;
      end else if (op < 8'h40 && op[3:0] == 4'h1) begin
         cnt = IMM_WORD;
      end
      return cnt;
   endfunction

   // Three-bit register field: B C D E H L (HL) A.
   function automatic operand_type reg_code(input logic [2:0] sel);
      operand_type opd;
      unique case (sel)
         3'd0: opd = OPD_B;
         3'd1: opd = OPD_C;
         3'd2: opd = OPD_D;
         3'd3: opd = OPD_E;
         3'd4: opd = OPD_H;
         3'd5: opd = OPD_L;
         3'd6: opd = OPD_IHL;
         default: opd = OPD_A;
      endcase
      return opd;
   endfunction

   // Three-bit ALU field: add adc sub sbc and xor or cp.
   function automatic op_kind_type alu_kind(input logic [2:0] sel);
      op_kind_type kind;
      unique case (sel)
         3'd0: kind = OP_ADD;
         3'd1: kind = OP_ADC;
         3'd2: kind = OP_SUB;
         3'd3: kind = OP_SBC;
         3'd4: kind = OP_AND;
         3'd5: kind = OP_XOR;
         3'd6: kind = OP_OR;
         default: kind = OP_CP;
      endcase
      return kind;
   endfunction

   // Register pair field, with SP or AF in the last slot.
   function automatic operand_type pair_code(input logic [1:0] sel, input logic use_af);
      operand_type opd;
      unique case (sel)
         2'd0: opd = OPD_BC;
         2'd1: opd = OPD_DE;
         2'd2: opd = OPD_HL;
         default: opd = use_af ? OPD_AF : OPD_SP;
      endcase
      return opd;
   endfunction

   // Main opcode table. Unknown opcodes and HALT give an all-zero record.
   function automatic rsp_type decode(input inst_type inst);
      rsp_type     r;
      logic [7:0]  op;
      logic [15:0] hi_addr;
      op      = inst.opcode;
      hi_addr = {HIGH_PAGE, inst.imm[7:0]};
      r       = '{FLAGS_DEFAULT, 16'h0000, OPD_NONE, OPD_NONE, OP_NOP};
      if (op < 8'h40 && op[2:0] == 3'd6) begin
         r = '{FLAGS_DEFAULT, inst.imm, OPD_IMM8, reg_code(op[5:3]), OP_LOAD8};
      end else if (op < 8'h40 && op[3:0] == 4'h1) begin
         r = '{FLAGS_DEFAULT, inst.imm, OPD_IMM16, pair_code(op[5:4], 1'b0), OP_LOAD16};
      end else if (op < 8'h40 && op[2:0] == 3'd4) begin
         r = '{FLAGS_DEFAULT, 16'h0000, OPD_NONE, reg_code(op[5:3]), OP_INC};
      end else if (op[7:6] == 2'b01) begin
         if (op != OPC_HALT) begin
            r = '{FLAGS_DEFAULT, 16'h0000, reg_code(op[2:0]), reg_code(op[5:3]), OP_LOAD8};
         end
      end else if (op[7:6] == 2'b10) begin
         r = '{FLAGS_DEFAULT, 16'h0000, reg_code(op[2:0]), OPD_A, alu_kind(op[5:3])};
      end else if (op[7:6] == 2'b11 && op[2:0] == 3'd6) begin
         r = '{FLAGS_DEFAULT, inst.imm, OPD_IMM8, OPD_A, alu_kind(op[5:3])};
      end else if (op[7:6] == 2'b11 && op[3:0] == 4'h5) begin
         r = '{FLAGS_DEFAULT, 16'h0000, pair_code(op[5:4], 1'b1), OPD_NONE, OP_PUSH};
      end else if (op[7:6] == 2'b11 && op[3:0] == 4'h1) begin
         r = '{FLAGS_DEFAULT, 16'h0000, OPD_NONE, pair_code(op[5:4], 1'b1), OP_POP};
      end else begin
         unique case (op)
            OPC_LD_BC_A:   r = '{FLAGS_DEFAULT, 16'h0000, OPD_A, OPD_IBC, OP_LOAD8};
            OPC_LD_DE_A:   r = '{FLAGS_DEFAULT, 16'h0000, OPD_A, OPD_IDE, OP_LOAD8};
            OPC_LD_HLI_A:  r = '{FLAGS_DEFAULT, 16'h0000, OPD_A, OPD_IHLI, OP_LOAD8};
            OPC_LD_HLD_A:  r = '{FLAGS_DEFAULT, 16'h0000, OPD_A, OPD_IHLD, OP_LOAD8};
            OPC_LD_A_BC:   r = '{FLAGS_DEFAULT, 16'h0000, OPD_IBC, OPD_A, OP_LOAD8};
            OPC_LD_A_DE:   r = '{FLAGS_DEFAULT, 16'h0000, OPD_IDE, OPD_A, OP_LOAD8};
            OPC_LD_A_HLI:  r = '{FLAGS_DEFAULT, 16'h0000, OPD_IHLI, OPD_A, OP_LOAD8};
            OPC_LD_A_HLD:  r = '{FLAGS_DEFAULT, 16'h0000, OPD_IHLD, OPD_A, OP_LOAD8};
            OPC_LDH_A_C:   r = '{FLAGS_DEFAULT, 16'h0000, OPD_HIC, OPD_A, OP_LOAD8};
            OPC_LDH_C_A:   r = '{FLAGS_DEFAULT, 16'h0000, OPD_A, OPD_HIC, OP_LOAD8};
            OPC_LD_A_A16:  r = '{FLAGS_DEFAULT, inst.imm, OPD_ADDR, OPD_A, OP_LOAD8};
            OPC_LD_A16_A:  r = '{FLAGS_DEFAULT, inst.imm, OPD_A, OPD_ADDR, OP_LOAD8};
            OPC_LDH_A_N:   r = '{FLAGS_DEFAULT, hi_addr, OPD_ADDR, OPD_A, OP_LOAD8};
            OPC_LDH_N_A:   r = '{FLAGS_DEFAULT, hi_addr, OPD_A, OPD_ADDR, OP_LOAD8};
            OPC_LD_SP_HL:  r = '{FLAGS_KEEP, 16'h0000, OPD_HL, OPD_SP, OP_LOAD16};
            OPC_LD_HL_SPN: r = '{FLAGS_SP_ADD, {8'h00, inst.imm[7:0]}, OPD_SPIMM, OPD_HL,
                                 OP_LOAD16};
            OPC_LD_A16_SP: r = '{FLAGS_KEEP, inst.imm, OPD_SP, OPD_ADDR, OP_LOAD16};
            default: ;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== hdl/gameboy_cpu_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// gameboy_cpu_instruction_decoder: LR35902 main-table instruction decoder.
// Takes the instruction stream one byte per request and returns one record
// per complete instruction. A byte is accepted in every cycle that the
// result side does not stall, so the sustained rate is one byte per cycle;
// a record is registered in the gather register and then in the result
// register after the last byte of its instruction. One prefix byte (CB, DD,
// ED or FD) is dropped and the next byte decodes with the main table; LDH
// with an immediate byte reports the full address FF00 plus that byte, and
// unknown opcodes give an all-zero record without taking immediate bytes.
// ----------------------------------------------------------------------------
module gameboy_cpu_instruction_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [3:0] op_kind, [8:4] dest_operand,
                                    // [13:9] src_operand, [29:14] immediate_value,
                                    // [31:30] flag_rule
);
   import gbd_pkg::*;

   logic     inst_valid;
   logic     inst_ready;
   inst_type inst;
   rsp_type  rsp;

   // Byte gathering stage.
   gbd_gather u_gather (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .byte_data  (req_tdata),
      .inst_valid (inst_valid),
      .inst_ready (inst_ready),
      .inst       (inst)
   );

   // Decode and result stage.
   gbd_format u_format (
      .clock      (clock),
      .reset      (reset),
      .inst_valid (inst_valid),
      .inst_ready (inst_ready),
      .inst       (inst),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = rsp;

endmodule

// ===== hdl/gbd_gather.sv =====
// ----------------------------------------------------------------------------
// gbd_gather: instruction byte gatherer.
// Drops one prefix byte, holds the opcode and its immediate bytes, and
// registers one complete instruction when its last byte arrives.
// ----------------------------------------------------------------------------
module gbd_gather (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   output logic              byte_ready,
   input  logic [7:0]        byte_data,
   output logic              inst_valid,
   input  logic              inst_ready,
   output gbd_pkg::inst_type inst
);
   import gbd_pkg::*;

   logic [1:0]    pending_ff, pending_in;
   logic          prefix_ff, prefix_in;
   logic [7:0]    held_op_ff, held_op_in;
   logic [7:0]    held_low_ff, held_low_in;
   logic          inst_valid_ff, inst_valid_in;
   inst_type      inst_ff, inst_in;
   logic          take;
   logic          emit;
   logic          is_prefix;
   imm_count_type new_count;

   // A byte is taken whenever the instruction register is free or drains now.
   assign byte_ready = !inst_valid_ff || inst_ready;
   assign take       = byte_valid && byte_ready;
   assign is_prefix  = byte_data == PREFIX_CB || byte_data == PREFIX_DD ||
                       byte_data == PREFIX_ED || byte_data == PREFIX_FD;
   assign new_count  = imm_count(byte_data);

   // Byte counter and prefix tracking.
   always_comb begin
      pending_in  = pending_ff;
      prefix_in   = prefix_ff;
      held_op_in  = held_op_ff;
      held_low_in = held_low_ff;
      inst_in     = inst_ff;
      emit        = 1'b0;
      if (take) begin
         priority if (pending_ff == 2'd0) begin
            if (!prefix_ff && is_prefix) begin
               prefix_in = 1'b1;
            end else begin
               prefix_in = 1'b0;
               if (new_count == IMM_NONE) begin
                  emit    = 1'b1;
                  inst_in = '{16'h0000, byte_data};
               end else begin
                  held_op_in = byte_data;
                  pending_in = new_count;
               end
            end
         end else if (pending_ff == 2'd2) begin
            held_low_in = byte_data;
            pending_in  = 2'd1;
         end else begin
            pending_in = 2'd0;
            emit       = 1'b1;
            if (imm_count(held_op_ff) == IMM_WORD) begin
               inst_in = '{{byte_data, held_low_ff}, held_op_ff};
            end else begin
               inst_in = '{{8'h00, byte_data}, held_op_ff};
            end
         end
      end
      inst_valid_in = emit || (inst_valid_ff && !inst_ready);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= 2'd0;
         prefix_ff     <= 1'b0;
         inst_valid_ff <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         prefix_ff     <= prefix_in;
         inst_valid_ff <= inst_valid_in;
      end
   end

   // Held bytes and the assembled instruction.
   always_ff @(posedge clock) begin
      held_op_ff  <= held_op_in;
      held_low_ff <= held_low_in;
      inst_ff     <= inst_in;
   end

   assign inst_valid = inst_valid_ff;
   assign inst       = inst_ff;

endmodule

// ===== hdl/gbd_format.sv =====
// ----------------------------------------------------------------------------
// gbd_format: opcode table lookup and result register.
// Decodes one gathered instruction into a result record and holds it until
// the result channel takes it.
// ----------------------------------------------------------------------------
module gbd_format (
   input  logic              clock,
   input  logic              reset,
   input  logic              inst_valid,
   output logic              inst_ready,
   input  gbd_pkg::inst_type inst,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gbd_pkg::rsp_type  rsp
);
   import gbd_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // The result register loads whenever it is empty or being emptied.
   assign inst_ready   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = inst_valid || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = (inst_valid && inst_ready) ? decode(inst) : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
